// ----- design/wqt_pkg.sv -----
// wqt_pkg: shared constants and types for the weighted quantile tracker
// depends on nothing; used by weighted_quantile_tracker through scoped names
package wqt_pkg;

  // weight and running-sum width
  localparam int WEIGHT_BITS = 48;

  // number of quantile thresholds and of result fields
  localparam int NUM_Q   = 5;
  localparam int NUM_OUT = 7;

  // divisor of the whisker thresholds
  localparam int WHISKER_DIV = 20;

  // quantile slots
  localparam int Q_LOW_WHISKER  = 0;
  localparam int Q_LOW_QUARTILE = 1;
  localparam int Q_MEDIAN       = 2;
  localparam int Q_HIGH_QUARTILE = 3;
  localparam int Q_HIGH_WHISKER = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TOTAL_WEIGHT     = 1'b0,
    CFG_ZERO_TOTAL_EMPTY = 1'b1
  } cfg_index_t;

  typedef logic [WEIGHT_BITS-1:0] weight_t;

endpackage

// ----- design/weighted_quantile_tracker.sv -----
// weighted_quantile_tracker: box-plot statistics over a time-sorted weighted run
// depends on wqt_pkg (constants, register indexes)
// the result of the beat marked tlast is registered (output register, or skid entry while the output is held)
// before m_axis_tvalid; one item per cycle while s_axis_tready is high; a total_weight write holds s_axis_tready
// low while total/20 is formed in WD_S4 to WD_FIX; a result register plus a skid entry absorb a waiting result;
// with both full the input stalls; reset (rst, synchronous): total_weight 0, zero_total_empty off, run state cleared
module weighted_quantile_tracker #(
  parameter int TIME_BITS = 48
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // input stream
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata from bit 0: item_time, item_weight, zero fill to bytes
  input  logic [((TIME_BITS + wqt_pkg::WEIGHT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: no_item
  input  logic                                         s_axis_tuser,
  input  logic                                         s_axis_tlast,
  // result stream
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata from bit 0: min_time, low_whisker_time, low_quartile_time, median_time,
  // high_quartile_time, high_whisker_time, max_time, zero fill to bytes
  output logic [((wqt_pkg::NUM_OUT * TIME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // configuration write channel
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  wqt_pkg::cfg_index_t                          cfg_index,
  input  logic [wqt_pkg::WEIGHT_BITS-1:0]              cfg_data
);

  localparam int WB     = wqt_pkg::WEIGHT_BITS;
  localparam int RES_W  = wqt_pkg::NUM_OUT * TIME_BITS;
  localparam int OUT_W  = ((wqt_pkg::NUM_OUT * TIME_BITS + 7) / 8) * 8;
  localparam logic [TIME_BITS-1:0] SENTINEL = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [WB-1:0]        SUM_MAX  = {WB{1'b1}};

  typedef logic [TIME_BITS-1:0] time_t;

  // steps of the shift-add divide by twenty
  typedef enum logic [2:0] {
    WD_IDLE,
    WD_S4,
    WD_S8,
    WD_S16,
    WD_S32,
    WD_REM,
    WD_FIX
  } wd_state_t;

  // configuration and thresholds
  wqt_pkg::weight_t total_weight;
  logic             zero_total_empty;
  logic             total_zero;
  wqt_pkg::weight_t thresh [wqt_pkg::NUM_Q];
  logic             load_total;

  // whisker threshold sequencer
  wd_state_t        wd_state;
  wqt_pkg::weight_t wd_q;
  logic             wd_fix;
  wqt_pkg::weight_t wd_rem;
  wqt_pkg::weight_t wd_quo;

  // run state
  wqt_pkg::weight_t running_sum;
  time_t            quantile_times [wqt_pkg::NUM_Q];
  logic [wqt_pkg::NUM_Q-1:0] quantile_valid;
  time_t            first_time;
  time_t            latest_time;
  logic             run_started;

  // next run state
  wqt_pkg::weight_t running_sum_next;
  time_t            quantile_times_next [wqt_pkg::NUM_Q];
  logic [wqt_pkg::NUM_Q-1:0] quantile_valid_next;
  time_t            first_time_next;
  time_t            latest_time_next;
  logic             run_started_next;

  // input beat fields
  logic             in_beat;
  time_t            item_time;
  wqt_pkg::weight_t item_weight;
  logic             take_item;
  logic [WB:0]      sum_wide;

  // result path
  logic             res_valid;
  logic [RES_W-1:0] res_data;
  logic             out_valid;
  logic [RES_W-1:0] out_data;
  logic             skid_valid;
  logic [RES_W-1:0] skid_data;
  logic             out_free;

  assign cfg_ready     = 1'b1;
  assign load_total    = cfg_valid && cfg_ready && (cfg_index == wqt_pkg::CFG_TOTAL_WEIGHT);
  assign s_axis_tready = (wd_state == WD_IDLE) && !skid_valid;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign item_time     = s_axis_tdata[TIME_BITS-1:0];
  assign item_weight   = s_axis_tdata[TIME_BITS+WB-1:TIME_BITS];
  assign take_item     = in_beat && !s_axis_tuser;

  // total/20 = (total/2)/10; estimate is at most one low, remainder fixes it
  assign wd_rem = (total_weight >> 1) - ((wd_q << 3) + (wd_q << 1));
  assign wd_quo = wd_q + {{(WB-1){1'b0}}, wd_fix};

  // configuration writes and threshold setup
  always_ff @(posedge clk) begin
    if (rst) begin
      total_weight     <= '0;
      zero_total_empty <= 1'b0;
      total_zero       <= 1'b1;
      wd_state         <= WD_IDLE;
      for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
        thresh[k] <= '0;
      end
    end else begin
      if (load_total) begin
        total_weight <= cfg_data;
        total_zero   <= (cfg_data == '0);
        thresh[wqt_pkg::Q_LOW_QUARTILE]  <= cfg_data >> 2;
        thresh[wqt_pkg::Q_MEDIAN]        <= cfg_data >> 1;
        thresh[wqt_pkg::Q_HIGH_QUARTILE] <= cfg_data - (cfg_data >> 2);
        wd_q     <= (cfg_data >> 2) + (cfg_data >> 3);
        wd_state <= WD_S4;
      end else begin
        case (wd_state)
          WD_S4: begin
            wd_q     <= wd_q + (wd_q >> 4);
            wd_state <= WD_S8;
          end
          WD_S8: begin
            wd_q     <= wd_q + (wd_q >> 8);
            wd_state <= WD_S16;
          end
          WD_S16: begin
            wd_q     <= wd_q + (wd_q >> 16);
            wd_state <= WD_S32;
          end
          WD_S32: begin
            wd_q     <= (wd_q + (wd_q >> 32)) >> 3;
            wd_state <= WD_REM;
          end
          WD_REM: begin
            wd_fix   <= (wd_rem >= WB'(10));
            wd_state <= WD_FIX;
          end
          WD_FIX: begin
            thresh[wqt_pkg::Q_LOW_WHISKER]  <= wd_quo;
            thresh[wqt_pkg::Q_HIGH_WHISKER] <= total_weight - wd_quo;
            wd_state <= WD_IDLE;
          end
          default: begin
          end
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wqt_pkg::CFG_ZERO_TOTAL_EMPTY: begin
            zero_total_empty <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // saturating running sum and quantile latches for the current beat
  always_comb begin
    sum_wide            = {1'b0, running_sum} + {1'b0, item_weight};
    running_sum_next    = running_sum;
    first_time_next     = first_time;
    latest_time_next    = latest_time;
    run_started_next    = run_started;
    quantile_valid_next = quantile_valid;
    for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
      quantile_times_next[k] = quantile_times[k];
    end
    if (take_item) begin
      running_sum_next = sum_wide[WB] ? SUM_MAX : sum_wide[WB-1:0];
      latest_time_next = item_time;
      run_started_next = 1'b1;
      if (!run_started) begin
        first_time_next = item_time;
      end
      for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
        if (!quantile_valid[k] && running_sum_next >= thresh[k]) begin
          quantile_times_next[k] = item_time;
          quantile_valid_next[k] = 1'b1;
        end
      end
    end
  end

  // result assembly on the last beat of a run
  always_comb begin
    res_valid = in_beat && s_axis_tlast;
    if (zero_total_empty && total_zero) begin
      res_data = {wqt_pkg::NUM_OUT{SENTINEL}};
    end else begin
      res_data[TIME_BITS-1:0] = first_time_next;
      for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
        res_data[(k+1)*TIME_BITS +: TIME_BITS] =
          quantile_valid_next[k] ? quantile_times_next[k] : SENTINEL;
      end
      res_data[(wqt_pkg::NUM_OUT-1)*TIME_BITS +: TIME_BITS] = latest_time_next;
    end
  end

  // run state registers, cleared on reset and after the last beat
  always_ff @(posedge clk) begin
    if (rst || (in_beat && s_axis_tlast)) begin
      running_sum    <= '0;
      quantile_valid <= '0;
      first_time     <= SENTINEL;
      latest_time    <= SENTINEL;
      run_started    <= 1'b0;
      for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
        quantile_times[k] <= SENTINEL;
      end
    end else begin
      running_sum    <= running_sum_next;
      quantile_valid <= quantile_valid_next;
      first_time     <= first_time_next;
      latest_time    <= latest_time_next;
      run_started    <= run_started_next;
      for (int k = 0; k < wqt_pkg::NUM_Q; k++) begin
        quantile_times[k] <= quantile_times_next[k];
      end
    end
  end

  // output register with a skid entry behind it
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        if (res_valid) begin
          out_data <= res_data;
        end
      end
    end else if (res_valid) begin
      skid_data  <= res_data;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);

endmodule
